// ===== rtl/gls_pkg.sv =====
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants for the gcd/lcm core
// Field widths of the stream payloads, ALU opcodes and the magnitude flags.
// ----------------------------------------------------------------------------
package gls_pkg;

    localparam int DEFAULT_WIDTH = 32;   // operand width used by the arithmetic
    localparam int OPERAND_BITS  = 32;   // width of each input field
    localparam int DIVISOR_BITS  = 32;   // width of the gcd result field
    localparam int MULTIPLE_BITS = 63;   // width of the lcm result field

    localparam int S_TDATA_BITS = 2 * OPERAND_BITS;                         // 64
    localparam int M_RAW_BITS   = DIVISOR_BITS + MULTIPLE_BITS;             // 95
    localparam int M_TDATA_BITS = ((M_RAW_BITS + 7) / 8) * 8;               // 96

    typedef enum logic [0:0] {
        GLS_OP_ADD = 1'b0,
        GLS_OP_SUB = 1'b1
    } gls_op_t;

    typedef struct packed {
        logic zero;
        logic one;
    } gls_mag_flags_t;

endpackage

// ===== rtl/gls_mag.sv =====
// ----------------------------------------------------------------------------
// gls_mag: operand magnitude
// Takes the low WIDTH bits of a field as two's complement and returns the
// magnitude (most negative value maps to 2^(WIDTH-1)), with zero/one flags.
// ----------------------------------------------------------------------------
module gls_mag #(
    parameter int WIDTH = gls_pkg::DEFAULT_WIDTH
) (
    input  logic [gls_pkg::OPERAND_BITS-1:0] operand,
    output logic [WIDTH-1:0]                 magnitude,
    output gls_pkg::gls_mag_flags_t          flags
);
    import gls_pkg::*;

    logic [WIDTH+OPERAND_BITS-1:0] operand_ext;
    logic [WIDTH-1:0]              value;
    logic [WIDTH-1:0]              value_neg;

    // zero-extend, then keep WIDTH bits (covers WIDTH above and below the field)
    assign operand_ext = {{WIDTH{1'b0}}, operand};
    assign value       = operand_ext[WIDTH-1:0];
    assign value_neg   = ~value + {{(WIDTH-1){1'b0}}, 1'b1};
    assign magnitude   = value[WIDTH-1] ? value_neg : value;

    assign flags.zero = (value == '0);
    assign flags.one  = (magnitude == {{(WIDTH-1){1'b0}}, 1'b1});

endmodule

// ===== rtl/gls_alu.sv =====
// ----------------------------------------------------------------------------
// gls_alu: shared adder/subtractor
// One carry chain serves the gcd subtract, the divide trial subtract and
// the multiply accumulate.
// ----------------------------------------------------------------------------
module gls_alu #(
    parameter int WIDTH = 2 * gls_pkg::DEFAULT_WIDTH
) (
    input  gls_pkg::gls_op_t  op,
    input  logic [WIDTH-1:0]  a,
    input  logic [WIDTH-1:0]  b,
    output logic [WIDTH-1:0]  result,
    output logic              borrow
);
    import gls_pkg::*;

    logic             sub;
    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   full;

    assign sub    = (op == GLS_OP_SUB);
    assign b_eff  = sub ? ~b : b;
    assign full   = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
    assign result = full[WIDTH-1:0];
    // a < b on subtract
    assign borrow = sub & ~full[WIDTH];

endmodule

// ===== rtl/gcd_lcm_subtractive_core.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_subtractive_core: gcd and lcm of two signed operand magnitudes
// Binary gcd by shift and subtract, then lcm = (|a| / gcd) * |b| through a
// restoring divider and a shift-add multiplier, all on one shared adder.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata fields (lowest bit up)                    width
//  -------  ---  ----------------------------------------------  -----
//  s_       in   first_operand[31:0], second_operand[63:32]       64
//  m_       out  divisor[31:0], multiple[94:32], zero pad [95]     96
//
//  Steps: a request whose operands contain a zero, a unit magnitude or two
//  equal magnitudes goes from accept straight to the finish state. Otherwise
//  it runs G gcd steps (one shift or one subtract each, at most about
//  4*WIDTH), then WIDTH divide steps and WIDTH multiply steps, all
//  serialized on the single adder/subtractor.
//  s_tready is high only while the sequencer is idle; a finished result waits
//  in the output register, so the next request is taken while m_ is stalled.
//  Reset (aresetn low, synchronous) returns the sequencer to idle and drops
//  m_tvalid; datapath registers are not reset.
// ----------------------------------------------------------------------------
module gcd_lcm_subtractive_core #(
    parameter int WIDTH = gls_pkg::DEFAULT_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gls_pkg::S_TDATA_BITS-1:0] s_tdata,   // first_operand, second_operand
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gls_pkg::M_TDATA_BITS-1:0] m_tdata    // divisor, multiple, pad
);
    import gls_pkg::*;

    localparam int AW = 2 * WIDTH;        // product width
    localparam int KW = $clog2(WIDTH);    // shift and step counters

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_GCD    = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_FINISH = 5'b10000
    } gls_state_t;

    gls_state_t state_reg, state_next;

    logic [WIDTH-1:0]        ma_reg,  ma_next;    // |first|
    logic [WIDTH-1:0]        mb_reg,  mb_next;    // |second|
    logic [WIDTH-1:0]        x_reg,   x_next;     // gcd working values
    logic [WIDTH-1:0]        y_reg,   y_next;
    logic [KW-1:0]           k_reg,   k_next;     // common power of two
    logic [WIDTH-1:0]        g_reg,   g_next;     // gcd result
    logic [WIDTH-1:0]        n_reg,   n_next;     // dividend / quotient shifter
    logic [WIDTH-1:0]        rem_reg, rem_next;   // partial remainder
    logic [KW-1:0]           cnt_reg, cnt_next;   // divide/multiply step count
    logic [AW-1:0]           acc_reg, acc_next;   // lcm accumulator
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg,  m_tdata_next;

    // operand magnitudes
    logic [WIDTH-1:0] mag_a, mag_b;
    gls_mag_flags_t   flags_a, flags_b;

    gls_mag #(.WIDTH(WIDTH)) u_mag_a (
        .operand   (s_tdata[OPERAND_BITS-1:0]),
        .magnitude (mag_a),
        .flags     (flags_a)
    );

    gls_mag #(.WIDTH(WIDTH)) u_mag_b (
        .operand   (s_tdata[S_TDATA_BITS-1:OPERAND_BITS]),
        .magnitude (mag_b),
        .flags     (flags_b)
    );

    // shared adder/subtractor
    gls_op_t       alu_op;
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_borrow;

    gls_alu #(.WIDTH(AW)) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    logic             x_gt_y;
    logic [WIDTH:0]   div_trial;     // remainder with next dividend bit shifted in
    logic             q_bit;
    logic             out_free;
    logic [WIDTH+DIVISOR_BITS-1:0] g_wide;
    logic [AW+MULTIPLE_BITS-1:0]   acc_wide;

    assign x_gt_y    = (x_reg > y_reg);
    assign div_trial = {rem_reg, n_reg[WIDTH-1]};
    assign q_bit     = ~alu_borrow;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // result fields: truncate or zero-extend to the stream widths
    assign g_wide   = {{DIVISOR_BITS{1'b0}}, g_reg};
    assign acc_wide = {{MULTIPLE_BITS{1'b0}}, acc_reg};

    // adder operand select, one use per state
    always_comb begin
        alu_op = GLS_OP_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_GCD: begin
                // larger minus smaller
                alu_a = AW'(x_gt_y ? x_reg : y_reg);
                alu_b = AW'(x_gt_y ? y_reg : x_reg);
            end
            ST_DIV: begin
                alu_a = AW'(div_trial);
                alu_b = AW'(x_reg);
            end
            ST_MUL: begin
                alu_op = GLS_OP_ADD;
                alu_a  = {acc_reg[AW-2:0], 1'b0};
                alu_b  = n_reg[WIDTH-1] ? AW'(mb_reg) : '0;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        k_next        = k_reg;
        g_next        = g_reg;
        n_next        = n_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ma_next = mag_a;
                    mb_next = mag_b;
                    x_next  = mag_a;
                    y_next  = mag_b;
                    k_next  = '0;
                    if (flags_a.zero || flags_b.zero) begin
                        g_next     = '0;
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end else if (flags_a.one || (mag_a == mag_b)) begin
                        g_next     = mag_a;
                        acc_next   = AW'(mag_b);
                        state_next = ST_FINISH;
                    end else if (flags_b.one) begin
                        g_next     = WIDTH'(1);
                        acc_next   = AW'(mag_a);
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg == y_reg) begin
                    // both odd and equal: x is the odd part of the gcd
                    g_next     = x_reg << k_reg;
                    n_next     = ma_reg >> k_reg;
                    rem_next   = '0;
                    cnt_next   = KW'(WIDTH - 1);
                    state_next = ST_DIV;
                end else if (x_gt_y) begin
                    x_next = alu_res[WIDTH-1:0];
                end else begin
                    y_next = alu_res[WIDTH-1:0];
                end
            end
            ST_DIV: begin
                // (|a| >> k) / odd gcd part, one quotient bit per step
                rem_next = q_bit ? alu_res[WIDTH-1:0] : div_trial[WIDTH-1:0];
                n_next   = {n_reg[WIDTH-2:0], q_bit};
                if (cnt_reg == '0) begin
                    acc_next   = '0;
                    cnt_next   = KW'(WIDTH - 1);
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_MUL: begin
                // quotient * |b|, msb first
                acc_next = alu_res;
                n_next   = n_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_BITS'({acc_wide[MULTIPLE_BITS-1:0],
                                                   g_wide[DIVISOR_BITS-1:0]});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        n_reg       <= n_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not leave idle");

    // gcd loop never holds a zero operand
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD) |-> ((x_reg != '0) && (y_reg != '0)))
        else $error("gcd working value went to zero");

    // divider remainder stays below the divisor
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < x_reg))
        else $error("divide remainder not below divisor");

    // a zero gcd comes only with a zero lcm
    a_zero_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[DIVISOR_BITS-1:0] == '0))
            |-> (m_tdata[M_RAW_BITS-1:DIVISOR_BITS] == '0))
        else $error("zero divisor with nonzero multiple");

endmodule

// ===== test/gcd_lcm_subtractive_core_tb.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_subtractive_core_tb: stream-level check of the gcd/lcm core
// Drives operand pairs into s_, predicts gcd and lcm of their magnitudes and
// compares every m_ result in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module gcd_lcm_subtractive_core_tb;
    import gls_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1880;
    localparam int CALM_ITEMS   = 200;        // tail of the run with no idling
    localparam int HOLD_AT      = 900;        // random request that starts the long stall
    localparam int HOLD_CYCLES  = 1500;       // receiver hold-off length
    localparam int TAIL_CYCLES  = 400;        // longer than the worst-case request latency
    localparam int CYCLE_LIMIT  = 2_000_000;  // several times the slowest correct run

    // One expected result plus the request that caused it, for reporting.
    typedef struct {
        logic [OPERAND_BITS-1:0]  first_operand;
        logic [OPERAND_BITS-1:0]  second_operand;
        logic [DIVISOR_BITS-1:0]  divisor;
        logic [MULTIPLE_BITS-1:0] multiple;
    } gcd_lcm_expect_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts on each accepted request, checks each result.
    // ------------------------------------------------------------------------
    class gcd_lcm_scoreboard;
        localparam int REPORT_LIMIT = 10;

        gcd_lcm_expect_t awaited_q[$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Core runs at WIDTH = OPERAND_BITS, so no upper input bits to drop.
        static function gcd_lcm_expect_t predict_gcd_lcm(logic [OPERAND_BITS-1:0] a,
                                                         logic [OPERAND_BITS-1:0] b);
            gcd_lcm_expect_t res;
            logic [63:0] ma, mb, x, y, r, g, l;
            // most negative value negates to itself: 2^31 as unsigned magnitude
            ma = {32'd0, a[OPERAND_BITS-1] ? (~a + 32'd1) : a};
            mb = {32'd0, b[OPERAND_BITS-1] ? (~b + 32'd1) : b};
            if (ma == 0 || mb == 0) begin
                g = 0;
                l = 0;
            end else if (ma == 1 || ma == mb) begin
                g = ma;
                l = mb;
            end else if (mb == 1) begin
                g = 1;
                l = ma;
            end else begin
                x = ma;
                y = mb;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                g = x;
                l = (ma / g) * mb;
            end
            res.first_operand  = a;
            res.second_operand = b;
            res.divisor        = g[DIVISOR_BITS-1:0];
            res.multiple       = l[MULTIPLE_BITS-1:0];
            return res;
        endfunction

        function void note_request(logic [OPERAND_BITS-1:0] a, logic [OPERAND_BITS-1:0] b);
            awaited_q.push_back(predict_gcd_lcm(a, b));
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] tdata);
            gcd_lcm_expect_t          want;
            logic [DIVISOR_BITS-1:0]  got_div;
            logic [MULTIPLE_BITS-1:0] got_mul;
            got_div = tdata[DIVISOR_BITS-1:0];
            got_mul = tdata[DIVISOR_BITS +: MULTIPLE_BITS];
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: divisor %h multiple %h", got_div, got_mul);
                return;
            end
            want = awaited_q.pop_front();
            if (got_div !== want.divisor || got_mul !== want.multiple) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch a=%h b=%h: divisor exp %h got %h, multiple exp %h got %h",
                             want.first_operand, want.second_operand,
                             want.divisor, got_div, want.multiple, got_mul);
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. All inputs known from time zero.
    // ------------------------------------------------------------------------
    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;   // first_operand, second_operand
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;         // divisor, multiple, pad

    bit          calm         = 1'b0;   // no idling on either side
    bit          hold_off_req = 1'b0;   // set by stimulus, cleared by receiver
    int unsigned cycle_count  = 0;

    gcd_lcm_scoreboard lcm_checker;

    always #HALF_PERIOD aclk = ~aclk;

    gcd_lcm_subtractive_core #(
        .WIDTH(DEFAULT_WIDTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor: values read here are the ones present at the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            lcm_checker.check_result(m_tdata);
    end

    // Receiver: short random stalls, one long hold-off on request, none when calm.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && aresetn && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one request, hold it until accepted, then maybe drop tvalid and idle.
    // tvalid stays high across back-to-back requests.
    task automatic send_request(input logic [OPERAND_BITS-1:0] a,
                                input logic [OPERAND_BITS-1:0] b);
        s_tdata <= {b, a};
        if (!s_tvalid)
            s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        lcm_checker.note_request(a, b);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Drop tvalid and wait for every outstanding result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (lcm_checker.pending() != 0) @(posedge aclk);
    endtask

    // Random operand pair, weighted toward pairs with a shared factor so the
    // gcd loop does real work, with raw noise and the special magnitudes mixed in.
    function automatic void pick_operands(output logic [OPERAND_BITS-1:0] a,
                                          output logic [OPERAND_BITS-1:0] b);
        int unsigned             pick;
        logic [OPERAND_BITS-1:0] k;
        logic [OPERAND_BITS-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            k = $urandom_range(1, 1 << $urandom_range(1, 16));
            a = k * $urandom_range(1, 40000);
            b = k * $urandom_range(1, 40000);
        end else if (pick < 60) begin
            a = $urandom;
            b = $urandom;
        end else if (pick < 72) begin
            a = $urandom_range(0, 40);
            b = $urandom_range(0, 40);
        end else if (pick < 82) begin
            a = ($urandom >> $urandom_range(0, 31)) << $urandom_range(0, 12);
            b = ($urandom >> $urandom_range(0, 31)) << $urandom_range(0, 12);
        end else begin
            case ($urandom_range(0, 5))
                0:       a = '0;
                1:       a = 32'd1;
                2:       a = 32'h8000_0000;
                3:       a = 32'h7fff_ffff;
                4:       a = 32'd1 << $urandom_range(0, 31);
                default: a = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       b = ~a + 32'd1;   // equal magnitude, opposite sign
                1:       b = a;
                2:       b = $urandom_range(0, 1);
                default: b = $urandom;
            endcase
            if ($urandom_range(0, 1)) begin
                t = a;
                a = b;
                b = t;
            end
        end
        if ($urandom_range(0, 1))
            a = ~a + 32'd1;
        if ($urandom_range(0, 1))
            b = ~b + 32'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [OPERAND_BITS-1:0] op_a;
        logic [OPERAND_BITS-1:0] op_b;

        lcm_checker = new();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zeros, unit magnitudes, equal magnitudes, most negative,
        // largest positive, coprime extremes and a few ordinary pairs.
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'd12345);
        send_request(-32'sd77,      32'h0000_0000);
        send_request(32'h0000_0000, 32'd1);
        send_request(32'd1,         32'd1);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        send_request(32'd1,         32'h8000_0000);
        send_request(32'hffff_ffff, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'd1);
        send_request(32'h8000_0000, 32'hffff_ffff);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h7fff_ffff, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'h8000_0001);
        send_request(-32'sd5,       32'd5);
        send_request(32'h8000_0000, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'h7fff_fffe);
        send_request(32'h8000_0000, 32'h4000_0000);
        send_request(32'h8000_0000, 32'd6);
        send_request(32'd12,        32'd18);
        send_request(-32'sd12,      32'd18);
        send_request(32'd1071,      -32'sd462);
        send_request(32'd196608,    32'd327680);
        send_request(32'd2,         32'd3);
        send_request(32'haaaa_aaaa, 32'h5555_5555);

        // Sender pause: let every result come out before going on.
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT)
                hold_off_req = 1'b1;   // receiver stalls, core fills and blocks s_
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick_operands(op_a, op_b);
            send_request(op_a, op_b);
        end
        s_tvalid <= 1'b0;

        while (lcm_checker.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (lcm_checker.mismatches == 0 && lcm_checker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== gcd_lcm_subtractive_core.f =====
rtl/gls_pkg.sv
rtl/gls_mag.sv
rtl/gls_alu.sv
rtl/gcd_lcm_subtractive_core.sv
test/gcd_lcm_subtractive_core_tb.sv
